>>> src/lsas_pkg.sv
package lsas_pkg;

   // Widths fixed by the item fields and by the largest array (eight sensors)
   localparam int MAX_SENSORS = 8;
   localparam int RD_W        = 10;   // one reading
   localparam int TOT_W       = 13;   // sum of up to eight readings
   localparam int WS_W        = 16;   // one side of the weighted sum, also (N-1)*total
   localparam int POS_W       = 14;   // signed Q12 position
   localparam int DIV_BITS    = 13;   // quotient bits, magnitude 0..4096
   localparam int MEAN_SHIFT  = 17;   // reciprocal scale for the mean

   localparam logic [RD_W-1:0] THRESHOLD_RESET = 10'd100;

   typedef struct packed {
      logic [RD_W-1:0]  peak_level;
      logic [TOT_W-1:0] total;
      logic [WS_W-1:0]  wsum_left;
      logic [WS_W-1:0]  wsum_right;
      logic             found;
   } lsas_work_type;

endpackage

>>> src/lsas_ifs.sv
interface lsas_req_if;
   import lsas_pkg::*;

   logic            valid;
   logic            ready;
   logic [RD_W-1:0] reading_0;
   logic [RD_W-1:0] reading_1;
   logic [RD_W-1:0] reading_2;
   logic [RD_W-1:0] reading_3;
   logic [RD_W-1:0] reading_4;
   logic [RD_W-1:0] reading_5;
   logic [RD_W-1:0] reading_6;
   logic [RD_W-1:0] reading_7;

   modport source (
      output valid, reading_0, reading_1, reading_2, reading_3,
             reading_4, reading_5, reading_6, reading_7,
      input  ready
   );
   modport sink (
      input  valid, reading_0, reading_1, reading_2, reading_3,
             reading_4, reading_5, reading_6, reading_7,
      output ready
   );
endinterface

interface lsas_rsp_if;
   import lsas_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [RD_W-1:0]         max_level;
   logic [RD_W-1:0]         mean_level;
   logic signed [POS_W-1:0] line_position;
   logic                    position_valid;
   logic                    line_found;

   modport source (
      output valid, max_level, mean_level, line_position, position_valid, line_found,
      input  ready
   );
   modport sink (
      input  valid, max_level, mean_level, line_position, position_valid, line_found,
      output ready
   );
endinterface

>>> src/lsas_front.sv
module lsas_front #(
   parameter int NUM_SENSORS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   lsas_req_if.sink                  req_chan,
   input  logic                      csr_wr_en,
   input  logic [lsas_pkg::RD_W-1:0] csr_wr_data,
   output lsas_pkg::lsas_work_type   word_out,
   output logic                      word_valid,
   input  logic                      word_ready
);
   import lsas_pkg::*;

   logic [RD_W-1:0]        threshold_ff, threshold_in;
   logic [RD_W-1:0]        rd [MAX_SENSORS];
   logic [MAX_SENSORS-1:0] above;
   logic                   pre_seen, bad;

   // hold the threshold until a write
   always_comb begin
      threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign rd[0] = req_chan.reading_0;
   assign rd[1] = req_chan.reading_1;
   assign rd[2] = req_chan.reading_2;
   assign rd[3] = req_chan.reading_3;
   assign rd[4] = req_chan.reading_4;
   assign rd[5] = req_chan.reading_5;
   assign rd[6] = req_chan.reading_6;
   assign rd[7] = req_chan.reading_7;

   // classify: peak, total, one-sided weighted sums, threshold pattern
   always_comb begin
      int w;
      word_out = '0;
      above    = '0;
      w        = 0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
         if (i < NUM_SENSORS) begin
            w = 2 * i - (NUM_SENSORS - 1);
            if (rd[i] > word_out.peak_level) begin
               word_out.peak_level = rd[i];
            end
            word_out.total = word_out.total + TOT_W'(rd[i]);
            if (w < 0) begin
               word_out.wsum_left = word_out.wsum_left + WS_W'(rd[i]) * WS_W'(-w);
            end else begin
               word_out.wsum_right = word_out.wsum_right + WS_W'(rd[i]) * WS_W'(w);
            end
            above[i] = rd[i] > threshold_ff;
         end
      end
      // flag a sensor above threshold that sits two or more past an earlier one
      pre_seen = 1'b0;
      bad      = 1'b0;
      for (int j = 2; j < MAX_SENSORS; j++) begin
         pre_seen = pre_seen | above[j-2];
         bad      = bad | (above[j] & pre_seen);
      end
      word_out.found = (|above) & ~bad;
   end

   assign word_valid     = req_chan.valid;
   assign req_chan.ready = word_ready;

endmodule

>>> src/lsas_fifo.sv
module lsas_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  lsas_pkg::lsas_work_type push_word,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output lsas_pkg::lsas_work_type pop_word
);
   import lsas_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lsas_work_type  mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_word   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> src/lsas_back.sv
module lsas_back #(
   parameter int NUM_SENSORS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lsas_pkg::lsas_work_type word_in,
   input  logic                    word_valid,
   output logic                    word_ready,
   lsas_rsp_if.source              rsp_chan
);
   import lsas_pkg::*;

   localparam int PROD_W   = TOT_W + MEAN_SHIFT;
   localparam int MEAN_MUL = ((1 << MEAN_SHIFT) + NUM_SENSORS - 1) / NUM_SENSORS;
   localparam int LAST     = DIV_BITS;

   // stage 0 prepares, stages 1..DIV_BITS each settle one quotient bit
   logic                vld_ff [0:LAST];
   logic                vld_in [0:LAST];
   logic [WS_W-1:0]     den_ff [0:LAST-1];
   logic [WS_W-1:0]     den_in [0:LAST-1];
   logic [WS_W-1:0]     rem_ff [0:LAST-1];
   logic [WS_W-1:0]     rem_in [0:LAST-1];
   logic [DIV_BITS-1:0] quot_ff [1:LAST];
   logic [DIV_BITS-1:0] quot_in [1:LAST];
   logic [RD_W-1:0]     peak_ff [0:LAST];
   logic [RD_W-1:0]     peak_in [0:LAST];
   logic [RD_W-1:0]     mean_ff [1:LAST];
   logic [RD_W-1:0]     mean_in [1:LAST];
   logic                neg_ff [0:LAST];
   logic                neg_in [0:LAST];
   logic                pvld_ff [0:LAST];
   logic                pvld_in [0:LAST];
   logic                fnd_ff [0:LAST];
   logic                fnd_in [0:LAST];
   logic [PROD_W-1:0]   prod_ff, prod_in;

   logic                    out_vld_ff, out_vld_in;
   logic [RD_W-1:0]         out_max_ff, out_max_in;
   logic [RD_W-1:0]         out_mean_ff, out_mean_in;
   logic signed [POS_W-1:0] out_pos_ff, out_pos_in;
   logic                    out_pvld_ff, out_pvld_in;
   logic                    out_fnd_ff, out_fnd_in;

   logic                    advance;
   logic [WS_W:0]           src [1:LAST];
   logic                    qbit [1:LAST];
   logic [POS_W-1:0]        mag;

   // the whole pipe moves when the output register is free or being taken
   assign advance    = ~out_vld_ff | rsp_chan.ready;
   assign word_ready = advance;

   always_comb begin
      // stage 0: sign and magnitude of the weighted sum, divisor, mean product
      vld_in[0]  = word_valid;
      peak_in[0] = word_in.peak_level;
      fnd_in[0]  = word_in.found;
      pvld_in[0] = word_in.total != '0;
      neg_in[0]  = word_in.wsum_left > word_in.wsum_right;
      rem_in[0]  = neg_in[0] ? word_in.wsum_left - word_in.wsum_right
                             : word_in.wsum_right - word_in.wsum_left;
      den_in[0]  = WS_W'(word_in.total) * WS_W'(NUM_SENSORS - 1);
      prod_in    = PROD_W'(word_in.total) * PROD_W'(MEAN_MUL);

      for (int s = 1; s <= LAST; s++) begin
         src[s]  = (s == 1) ? {1'b0, rem_ff[0]} : {rem_ff[s-1], 1'b0};
         qbit[s] = src[s] >= {1'b0, den_ff[s-1]};
         if (s < LAST) begin
            rem_in[s] = qbit[s] ? WS_W'(src[s] - {1'b0, den_ff[s-1]}) : WS_W'(src[s]);
            den_in[s] = den_ff[s-1];
         end
         vld_in[s]  = vld_ff[s-1];
         peak_in[s] = peak_ff[s-1];
         neg_in[s]  = neg_ff[s-1];
         pvld_in[s] = pvld_ff[s-1];
         fnd_in[s]  = fnd_ff[s-1];
      end

      // first quotient bit and the mean enter at stage 1, then shift along
      quot_in[1] = DIV_BITS'(qbit[1]);
      mean_in[1] = prod_ff[MEAN_SHIFT +: RD_W];
      for (int s = 2; s <= LAST; s++) begin
         quot_in[s] = {quot_ff[s-1][DIV_BITS-2:0], qbit[s]};
         mean_in[s] = mean_ff[s-1];
      end

      // output stage: apply sign, force zero on an empty snapshot
      mag         = POS_W'(quot_ff[LAST]);
      out_vld_in  = vld_ff[LAST];
      out_max_in  = peak_ff[LAST];
      out_mean_in = mean_ff[LAST];
      out_pvld_in = pvld_ff[LAST];
      out_fnd_in  = fnd_ff[LAST];
      if (!pvld_ff[LAST]) begin
         out_pos_in = '0;
      end else if (neg_ff[LAST]) begin
         out_pos_in = -$signed(mag);
      end else begin
         out_pos_in = $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         for (int s = 0; s <= LAST; s++) begin
            vld_ff[s] <= vld_in[s];
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= LAST; s++) begin
            peak_ff[s] <= peak_in[s];
            neg_ff[s]  <= neg_in[s];
            pvld_ff[s] <= pvld_in[s];
            fnd_ff[s]  <= fnd_in[s];
         end
         for (int s = 0; s < LAST; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
         end
         for (int s = 1; s <= LAST; s++) begin
            quot_ff[s] <= quot_in[s];
            mean_ff[s] <= mean_in[s];
         end
         prod_ff     <= prod_in;
         out_max_ff  <= out_max_in;
         out_mean_ff <= out_mean_in;
         out_pos_ff  <= out_pos_in;
         out_pvld_ff <= out_pvld_in;
         out_fnd_ff  <= out_fnd_in;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.max_level      = out_max_ff;
   assign rsp_chan.mean_level     = out_mean_ff;
   assign rsp_chan.line_position  = out_pos_ff;
   assign rsp_chan.position_valid = out_pvld_ff;
   assign rsp_chan.line_found     = out_fnd_ff;

endmodule

>>> src/line_sensor_array_summary_top.sv
// Channel   Dir  Handshake          Word
// req_chan  in   valid/ready        reading_0 .. reading_7, 10 bits each
// rsp_chan  out  valid/ready        max_level, mean_level, line_position,
//                                   position_valid, line_found
// csr_*     in   csr_wr_en strobe   csr_wr_data = line_threshold
//
// One word per cycle in and out when nothing stalls; a word passes the queue write,
// one prepare stage, 13 restoring-divide stages and the output register.
// The divide pipeline, one quotient bit per stage, sets the latency.
// Reset is synchronous: threshold returns to 100, queue and pipe empty.
// A stalled rsp_chan freezes the back pipe; the queue absorbs four words
// before req_chan.ready drops.
module line_sensor_array_summary_top #(
   parameter int NUM_SENSORS = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   lsas_req_if.sink                  req_chan,
   lsas_rsp_if.source                rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [lsas_pkg::RD_W-1:0] csr_wr_data
);
   import lsas_pkg::*;

   // front to queue
   lsas_work_type front_word;
   logic          front_valid;
   logic          front_ready;

   // queue to back
   lsas_work_type back_word;
   logic          back_valid;
   logic          back_ready;

   // accept and classify each snapshot combinationally
   lsas_front #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .word_out    (front_word),
      .word_valid  (front_valid),
      .word_ready  (front_ready)
   );

   // decouple the front from back-pressure on the result side
   lsas_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_word  (front_word),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_word   (back_word)
   );

   // divide for the centroid, scale for the mean, drive the result word
   lsas_back #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .word_in    (back_word),
      .word_valid (back_valid),
      .word_ready (back_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> tb/line_sensor_array_summary_top_test.sv
`timescale 1ns / 1ps

module line_sensor_array_summary_top_test;
   import lsas_pkg::*;

   localparam int SENSORS     = 8;
   localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
   localparam int REPORT_MAX  = 10;
   localparam int PIPE_FLUSH  = 40;      // leave room beyond the pipeline latency
   localparam int HOLD_CYCLES = 250;     // long receiver hold-off

   // One snapshot: element 0 is the leftmost sensor
   typedef logic [SENSORS-1:0][RD_W-1:0] snapshot_word_type;

   // One result word, laid out like the rsp channel payload
   typedef struct packed {
      logic [RD_W-1:0]         max_level;
      logic [RD_W-1:0]         mean_level;
      logic signed [POS_W-1:0] line_position;
      logic                    position_valid;
      logic                    line_found;
   } summary_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [RD_W-1:0] csr_wr_data;

   lsas_req_if req_if();
   lsas_rsp_if rsp_if();

   line_sensor_array_summary_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock, 20 ns period
   always #10 clock = ~clock;

   // Testbench copy of the threshold register; changes only while the block is idle
   logic [RD_W-1:0] threshold_setting = THRESHOLD_RESET;

   // Summaries still owed by the block, oldest first
   summary_word_type expected_summaries[$];

   int  fail_count    = 0;
   int  cycle_count   = 0;
   bit  send_gaps_on  = 1'b1;   // random idle bursts on req side
   bit  rsp_stalls_on = 1'b1;   // random stall bursts on rsp side
   int  hold_off_left = 0;      // set at a rising edge, counted down by the rsp driver

   // -------------------------------------------------------------------------
   // Predictor: peak, floored mean, Q12 centroid truncated toward zero and
   // the line-detected flag, all from one snapshot and the threshold.
   // -------------------------------------------------------------------------
   function automatic summary_word_type predict_summary(snapshot_word_type r,
                                                        logic [RD_W-1:0] thr);
      summary_word_type s;
      int unsigned      peak, total, left_sum, right_sum, diff, den;
      int               mag, w2, first;
      bit               bad, neg;
      peak      = 0;
      total     = 0;
      left_sum  = 0;
      right_sum = 0;
      first     = -1;
      bad       = 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
         w2 = 2 * i - (SENSORS - 1);
         if (r[i] > peak) peak = r[i];
         total += r[i];
         if (w2 < 0) left_sum  += r[i] * (-w2);
         else        right_sum += r[i] * w2;
         // A reading counts only when strictly above the threshold
         if (r[i] > thr) begin
            if (first < 0) first = i;
            else if (i > first + 1) bad = 1'b1;
         end
      end
      s.max_level      = RD_W'(peak);
      s.mean_level     = RD_W'(total / SENSORS);
      s.position_valid = (total != 0);
      s.line_found     = (first >= 0) && !bad;
      if (total == 0) begin
         // All-dark-free snapshot: centroid undefined, force zero
         s.line_position = '0;
      end else begin
         neg  = left_sum > right_sum;
         diff = neg ? left_sum - right_sum : right_sum - left_sum;
         den  = (SENSORS - 1) * total;
         mag  = int'((diff * 4096) / den);
         s.line_position = POS_W'(neg ? -mag : mag);
      end
      return s;
   endfunction

   task automatic note_failure(string what, longint want, longint got);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // -------------------------------------------------------------------------
   // Input monitor: predict the summary of every word accepted on req_chan.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_req
      snapshot_word_type snap;
      if (!reset && req_if.valid && req_if.ready) begin
         snap[0] = req_if.reading_0;
         snap[1] = req_if.reading_1;
         snap[2] = req_if.reading_2;
         snap[3] = req_if.reading_3;
         snap[4] = req_if.reading_4;
         snap[5] = req_if.reading_5;
         snap[6] = req_if.reading_6;
         snap[7] = req_if.reading_7;
         expected_summaries.push_back(predict_summary(snap, threshold_setting));
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: compare each accepted rsp word with the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      summary_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_summaries.size() == 0) begin
            note_failure("unexpected rsp word", 0, 1);
         end else begin
            want = expected_summaries.pop_front();
            if (rsp_if.max_level !== want.max_level)
               note_failure("max_level", want.max_level, rsp_if.max_level);
            if (rsp_if.mean_level !== want.mean_level)
               note_failure("mean_level", want.mean_level, rsp_if.mean_level);
            if (rsp_if.line_position !== want.line_position)
               note_failure("line_position", want.line_position, rsp_if.line_position);
            if (rsp_if.position_valid !== want.position_valid)
               note_failure("position_valid", want.position_valid, rsp_if.position_valid);
            if (rsp_if.line_found !== want.line_found)
               note_failure("line_found", want.line_found, rsp_if.line_found);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: drive rsp ready at the falling edge. A requested hold-off wins,
   // then any running stall burst, then a chance of a new burst.
   // -------------------------------------------------------------------------
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            // Start a stall burst of random length, this cycle included
            stall_left = $urandom_range(1, 10) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offer one snapshot, optionally after an idle burst, and hold it
   // until accepted. Valid stays high on return so back-to-back words flow.
   // -------------------------------------------------------------------------
   task automatic send_snapshot(snapshot_word_type r);
      int gap;
      if (send_gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.reading_0 <= r[0];
      req_if.reading_1 <= r[1];
      req_if.reading_2 <= r[2];
      req_if.reading_3 <= r[3];
      req_if.reading_4 <= r[4];
      req_if.reading_5 <= r[5];
      req_if.reading_6 <= r[6];
      req_if.reading_7 <= r[7];
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and wait until every expected summary has come back
   task automatic wait_for_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the threshold register, only with the block drained
   task automatic set_line_threshold(logic [RD_W-1:0] value);
      wait_for_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      threshold_setting = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random snapshot: mostly clean lines (one or two adjacent dark sensors over
   // a light background), some broken lines, some noise and a few all-zero.
   task automatic build_random_snapshot(output snapshot_word_type r);
      int kind, f, g;
      int unsigned thr;
      thr  = threshold_setting;
      kind = $urandom_range(0, 99);
      for (int i = 0; i < SENSORS; i++) r[i] = RD_W'($urandom_range(0, 1023));
      if (kind < 4) begin
         r = '0;
      end else if (kind < 64 && thr < 1023) begin
         for (int i = 0; i < SENSORS; i++) r[i] = RD_W'($urandom_range(0, thr));
         f    = $urandom_range(0, SENSORS - 1);
         r[f] = RD_W'($urandom_range(thr + 1, 1023));
         if (f < SENSORS - 1 && $urandom_range(0, 1) == 1)
            r[f + 1] = RD_W'($urandom_range(thr + 1, 1023));
      end else if (kind < 84 && thr < 1023) begin
         // Two dark sensors with a gap between them: no line
         for (int i = 0; i < SENSORS; i++) r[i] = RD_W'($urandom_range(0, thr));
         f    = $urandom_range(0, SENSORS - 3);
         g    = $urandom_range(f + 2, SENSORS - 1);
         r[f] = RD_W'($urandom_range(thr + 1, 1023));
         r[g] = RD_W'($urandom_range(thr + 1, 1023));
      end
   endtask

   task automatic send_random_words(int count);
      snapshot_word_type r;
      repeat (count) begin
         build_random_snapshot(r);
         send_snapshot(r);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Field extremes, each sensor alone, and the flag edge cases at reset threshold
   task automatic test_directed_extremes();
      snapshot_word_type r;
      r = '0;               send_snapshot(r);   // all zero: position forced off
      r = '1;               send_snapshot(r);   // all full scale
      for (int i = 0; i < SENSORS; i++) begin
         // One dark sensor: sweep from full left to full right
         r = '0; r[i] = 10'd1023; send_snapshot(r);
      end
      r = '0; r[3] = 10'd500; r[4] = 10'd500; send_snapshot(r);   // adjacent pair
      r = '0; r[2] = 10'd500; r[3] = 10'd500; r[4] = 10'd500;
      send_snapshot(r);                                            // three wide
      r = '0; r[1] = 10'd500; r[5] = 10'd500; send_snapshot(r);   // split line
      for (int i = 0; i < SENSORS; i++) r[i] = 10'd100;           // at threshold
      send_snapshot(r);
      r = '0; r[0] = 10'd101; send_snapshot(r);                   // just above
      for (int i = 0; i < SENSORS; i++) r[i] = i[0] ? 10'h155 : 10'h2AA;
      send_snapshot(r);
      for (int i = 0; i < SENSORS; i++) r[i] = i[0] ? 10'h2AA : 10'h155;
      send_snapshot(r);
      r = '0; r[0] = 10'd1; r[7] = 10'd1; send_snapshot(r);       // balanced, tiny sum
      r = '0; r[6] = 10'd1023; r[7] = 10'd1023; send_snapshot(r); // pair on right edge
      r = '0; r[7] = 10'd1; send_snapshot(r);                     // smallest nonzero
   endtask

   // Threshold at both ends of its range
   task automatic test_threshold_extremes();
      snapshot_word_type r;
      set_line_threshold(10'd0);
      r = '0; r[2] = 10'd1; send_snapshot(r);                     // any light counts
      for (int i = 0; i < SENSORS; i++) r[i] = 10'd1;
      send_snapshot(r);                                            // everything dark
      r = '0; send_snapshot(r);                                    // nothing exceeds zero
      set_line_threshold(10'd1023);
      r = '1; send_snapshot(r);                                    // nothing can exceed
      r = '0; r[5] = 10'd1023; send_snapshot(r);
      set_line_threshold(10'd1022);
      r = '0; r[5] = 10'd1023; send_snapshot(r);                   // one step under max
   endtask

   // Random words over several threshold settings, with idling on both sides
   task automatic test_random_sweep();
      set_line_threshold(10'd0);
      send_random_words(200);
      set_line_threshold(10'd300);
      send_random_words(200);
      set_line_threshold(RD_W'($urandom_range(1, 1022)));
      send_random_words(200);
      set_line_threshold(10'd1023);
      send_random_words(100);
      set_line_threshold(10'd1022);
      send_random_words(100);
   endtask

   // Hold the receiver off while the sender keeps offering; the block must fill
   // up, stall req_chan and lose nothing.
   task automatic test_backpressure_hold();
      set_line_threshold(THRESHOLD_RESET);
      send_gaps_on = 1'b0;
      @(posedge clock);
      hold_off_left = HOLD_CYCLES;
      send_random_words(40);
      send_gaps_on = 1'b1;
   endtask

   // Last part: no idling anywhere, one word per cycle
   task automatic test_full_rate_stream();
      wait_for_idle();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      send_random_words(200);
   endtask

   initial begin
      // Hold every block input at a known value before the first edge
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.reading_0 = '0;
      req_if.reading_1 = '0;
      req_if.reading_2 = '0;
      req_if.reading_3 = '0;
      req_if.reading_4 = '0;
      req_if.reading_5 = '0;
      req_if.reading_6 = '0;
      req_if.reading_7 = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_threshold_extremes();
      test_random_sweep();
      test_backpressure_hold();
      test_full_rate_stream();

      // Drain, then give any stray word time to show up
      wait_for_idle();
      repeat (PIPE_FLUSH) @(posedge clock);
      if (fail_count == 0 && expected_summaries.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
